### rtl/core/clta_pkg.sv
// Shared types and constants of the cluster link table allocator.
package clta_pkg;

    localparam int DEF_MAX_CLUSTERS     = 16384;
    localparam int DEF_LINKS_PER_SECTOR = 128;

    localparam int ACTION_W   = 2;
    localparam int CLUSTER_W  = 32;
    localparam int STATUS_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CNT_W-1:0]     CNT_RESET = 15'd16384;
    localparam logic [VALUE_W-1:0]   END_MARK  = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0]   FREE_MARK = 32'h0000_0000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIND  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_GET   = 2'd2,
        ACT_CHAIN = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNMOUNTED = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NONE_FREE = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUNTED       = 2'd0,
        CFG_CLUSTER_COUNT = 2'd1
    } t_cfg_reg;

endpackage

### rtl/core/cluster_link_table_allocator.sv
// Cluster link table allocator: FAT-style link table with find, set, get and chain free.
//
// The table lives in one synchronous RAM of MAX_CLUSTERS 32-bit words (one read port,
// one write port, registered read). After reset a clearing pass writes every word,
// entry zero with the end marker and the rest with zero (free); during the pass busy
// stays high and no word is taken (config writes still are).
// A word is taken when start is high and busy is low. Each result is shown for exactly
// one cycle with o_done high; there is no back-pressure, so the receiver must take it.
// What each action takes from the accepting word to its result:
//   - not mounted (any action), index out of range on set or get, find on an empty
//     volume, and set link: from idle, busy stays low so the next word can follow at once
//   - get link: one RAM read (S_GET)
//   - free chain: per freed cluster a read (S_FC_CHK), then a write back of zero (S_FC_WR);
//     a chain that stops on a bad index or the step bound stops in S_FC_CHK
//   - find free: the bit-serial divider (S_DIV_MOD) reduces the hint modulo the sector
//     count, DW = clog2(MAX_CLUSTERS+LINKS_PER_SECTOR) bits wide, then the scan
//     (S_SCAN) checks the entries with one RAM read per cycle. The sector count
//     itself is a shift, so LINKS_PER_SECTOR must be a power of two.
// Config port is always ready; write it only while the block is idle.
module cluster_link_table_allocator #(
    parameter int MAX_CLUSTERS     = clta_pkg::DEF_MAX_CLUSTERS,
    parameter int LINKS_PER_SECTOR = clta_pkg::DEF_LINKS_PER_SECTOR
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [clta_pkg::ACTION_W-1:0]    i_action,
    input  logic [clta_pkg::CLUSTER_W-1:0]   i_cluster,
    input  logic [clta_pkg::VALUE_W-1:0]     i_link_value,
    output logic                             o_done,
    output logic [clta_pkg::STATUS_W-1:0]    o_status,
    output logic [clta_pkg::VALUE_W-1:0]     o_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [clta_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clta_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import clta_pkg::*;

    // widths
    localparam int AW   = $clog2(MAX_CLUSTERS);              // table address
    localparam int CW   = $clog2(MAX_CLUSTERS + 1);          // cluster count
    localparam int NSEC = (MAX_CLUSTERS + LINKS_PER_SECTOR - 1) / LINKS_PER_SECTOR;
    localparam int SW   = (NSEC > 1) ? $clog2(NSEC) : 1;     // sector number
    localparam int JW   = $clog2(LINKS_PER_SECTOR);          // offset in sector
    localparam int DW   = $clog2(MAX_CLUSTERS + LINKS_PER_SECTOR); // divider
    localparam int DCW  = $clog2(DW);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b000_0001,
        S_IDLE     = 7'b000_0010,
        S_GET      = 7'b000_0100,
        S_DIV_MOD  = 7'b000_1000,
        S_SCAN     = 7'b001_0000,
        S_FC_CHK   = 7'b010_0000,
        S_FC_WR    = 7'b100_0000
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [SW-1:0]     r_hint, n_hint;
    logic              r_done, n_done;
    logic              r_chk_v, n_chk_v;
    logic              r_mounted;
    logic [CNT_W-1:0]  r_cc;

    // datapath
    t_status           r_status, n_status;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [CLUSTER_W-1:0] r_cur, n_cur;
    logic [CW-1:0]     r_steps, n_steps;
    logic [DW-1:0]     r_dv_num, n_dv_num;
    logic [DW-1:0]     r_dv_den, n_dv_den;
    logic [DW-1:0]     r_dv_rem, n_dv_rem;
    logic [DCW-1:0]    r_dv_cnt, n_dv_cnt;
    logic [AW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_sec, n_sec;
    logic [JW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_left, n_left;
    logic [AW-1:0]     r_chk_idx, n_chk_idx;
    logic [SW-1:0]     r_chk_sec, n_chk_sec;

    // link table RAM
    logic [VALUE_W-1:0] link_mem [MAX_CLUSTERS];
    logic [VALUE_W-1:0] r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;

    // effective cluster count, clamped to the table size
    logic [31:0]        cc_wide;
    logic [CW-1:0]      cc_eff;
    logic               in_range;
    // sector count = ceil(count / sector size), sector size a power of two
    logic [DW-1:0]      secs_sum;
    logic [DW-1:0]      num_secs;

    assign cc_wide  = {{(32-CNT_W){1'b0}}, r_cc};
    assign cc_eff   = (cc_wide > 32'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS) : cc_wide[CW-1:0];
    assign in_range = i_cluster < 32'(cc_eff);
    assign secs_sum = DW'(cc_eff) + DW'(LINKS_PER_SECTOR - 1);
    assign num_secs = secs_sum >> JW;

    // one restoring-division step for hint mod sectors
    logic [DW:0]        dv_trial;
    logic               dv_ge;
    logic [DW:0]        dv_diff;
    logic [DW-1:0]      dv_rem_n;
    logic [31:0]        scan_base;

    assign dv_trial  = {r_dv_rem, r_dv_num[DW-1]};
    assign dv_ge     = dv_trial >= {1'b0, r_dv_den};
    assign dv_diff   = dv_trial - {1'b0, r_dv_den};
    assign dv_rem_n  = dv_ge ? dv_diff[DW-1:0] : dv_trial[DW-1:0];
    // first entry of the start sector
    assign scan_base = 32'(dv_rem_n[SW-1:0]) * 32'(LINKS_PER_SECTOR);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_hint     = r_hint;
        n_done     = 1'b0;
        n_chk_v    = r_chk_v;
        n_status   = r_status;
        n_value    = r_value;
        n_cur      = r_cur;
        n_steps    = r_steps;
        n_dv_num   = r_dv_num;
        n_dv_den   = r_dv_den;
        n_dv_rem   = r_dv_rem;
        n_dv_cnt   = r_dv_cnt;
        n_idx      = r_idx;
        n_sec      = r_sec;
        n_j        = r_j;
        n_left     = r_left;
        n_chk_idx  = r_chk_idx;
        n_chk_sec  = r_chk_sec;
        mem_we     = 1'b0;
        mem_waddr  = r_cur[AW-1:0];
        mem_wdata  = FREE_MARK;
        mem_raddr  = r_cur[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = (r_clr_addr == '0) ? END_MARK : FREE_MARK;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_CLUSTERS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                mem_raddr = i_cluster[AW-1:0];
                if (start) begin
                    if (!r_mounted) begin
                        n_done   = 1'b1;
                        n_status = ST_UNMOUNTED;
                        n_value  = END_MARK;
                    end else begin
                        unique case (t_action'(i_action))
                            ACT_FIND: begin
                                if (cc_eff == '0) begin
                                    n_done   = 1'b1;
                                    n_status = ST_NONE_FREE;
                                    n_value  = END_MARK;
                                end else begin
                                    // start sector = hint mod sectors
                                    n_dv_num = DW'(r_hint);
                                    n_dv_den = num_secs;
                                    n_dv_rem = '0;
                                    n_dv_cnt = '0;
                                    n_state  = S_DIV_MOD;
                                end
                            end
                            ACT_SET: begin
                                n_done = 1'b1;
                                if (in_range) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = i_cluster[AW-1:0];
                                    mem_wdata = i_link_value;
                                    n_status  = ST_OK;
                                    n_value   = '0;
                                end else begin
                                    n_status  = ST_RANGE;
                                    n_value   = END_MARK;
                                end
                            end
                            ACT_GET: begin
                                if (in_range) begin
                                    n_state  = S_GET;
                                end else begin
                                    n_done   = 1'b1;
                                    n_status = ST_RANGE;
                                    n_value  = END_MARK;
                                end
                            end
                            ACT_CHAIN: begin
                                n_cur   = i_cluster;
                                n_steps = '0;
                                n_state = S_FC_CHK;
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_GET: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_value  = r_rdata;
                n_state  = S_IDLE;
            end

            S_DIV_MOD: begin
                n_dv_rem = dv_rem_n;
                n_dv_num = r_dv_num << 1;
                n_dv_cnt = r_dv_cnt + 1'b1;
                if (r_dv_cnt == DCW'(DW - 1)) begin
                    n_sec   = dv_rem_n[SW-1:0];
                    n_idx   = scan_base[AW-1:0];
                    n_j     = '0;
                    n_left  = cc_eff;
                    n_chk_v = 1'b0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // issue one read per cycle, check the registered word in the next cycle
                mem_raddr = r_idx;
                n_chk_v   = (r_left != '0);
                n_chk_idx = r_idx;
                n_chk_sec = r_sec;
                if (r_left != '0) begin
                    n_left = r_left - 1'b1;
                    if (CW'(r_idx) == cc_eff - 1'b1) begin
                        n_idx = '0;
                        n_sec = '0;
                        n_j   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        if (r_j == JW'(LINKS_PER_SECTOR - 1)) begin
                            n_j   = '0;
                            n_sec = r_sec + 1'b1;
                        end else begin
                            n_j   = r_j + 1'b1;
                        end
                    end
                end
                if (r_chk_v && (r_rdata == FREE_MARK)) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_value  = 32'(r_chk_idx);
                    n_hint   = r_chk_sec;
                    n_chk_v  = 1'b0;
                    n_state  = S_IDLE;
                end else if ((r_left == '0) && !r_chk_v) begin
                    n_done   = 1'b1;
                    n_status = ST_NONE_FREE;
                    n_value  = END_MARK;
                    n_state  = S_IDLE;
                end
            end

            S_FC_CHK: begin
                mem_raddr = r_cur[AW-1:0];
                if (r_cur == END_MARK) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_value  = '0;
                    n_state  = S_IDLE;
                end else if (r_steps >= cc_eff) begin
                    n_done   = 1'b1;
                    n_status = ST_TOO_LONG;
                    n_value  = END_MARK;
                    n_state  = S_IDLE;
                end else if (r_cur >= 32'(cc_eff)) begin
                    n_done   = 1'b1;
                    n_status = ST_RANGE;
                    n_value  = END_MARK;
                    n_state  = S_IDLE;
                end else begin
                    n_state  = S_FC_WR;
                end
            end

            S_FC_WR: begin
                // link word is back: free this cluster, follow the link
                mem_we    = 1'b1;
                mem_waddr = r_cur[AW-1:0];
                mem_wdata = FREE_MARK;
                n_cur     = r_rdata;
                n_steps   = r_steps + 1'b1;
                n_state   = S_FC_CHK;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_hint     <= '0;
            r_done     <= 1'b0;
            r_chk_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_hint     <= n_hint;
            r_done     <= n_done;
            r_chk_v    <= n_chk_v;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_value   <= n_value;
        r_cur     <= n_cur;
        r_steps   <= n_steps;
        r_dv_num  <= n_dv_num;
        r_dv_den  <= n_dv_den;
        r_dv_rem  <= n_dv_rem;
        r_dv_cnt  <= n_dv_cnt;
        r_idx     <= n_idx;
        r_sec     <= n_sec;
        r_j       <= n_j;
        r_left    <= n_left;
        r_chk_idx <= n_chk_idx;
        r_chk_sec <= n_chk_sec;
    end

    // link table RAM, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= link_mem[mem_raddr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mounted <= 1'b0;
            r_cc      <= CNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MOUNTED:       r_mounted <= i_cfg_data[0];
                CFG_CLUSTER_COUNT: r_cc      <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_value     = r_value;

    // a result only follows an accepted word or a running action
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past((start && !busy) || (r_state != S_IDLE)))
        else $error("result without a cause");

    // the search hint always names an existing sector
    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) < NSEC)
        else $error("search hint beyond sector count");

    // a chain write-back only follows its checked read
    a_chain_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FC_WR) |-> $past(r_state == S_FC_CHK))
        else $error("chain write-back without a checked read");

    // a set link writes the requested, in-range entry
    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == S_IDLE)) |->
            ((32'(mem_waddr) == i_cluster) && (i_cluster < 32'(cc_eff))))
        else $error("set link wrote an out-of-range entry");

endmodule

### tb/tb.sv
// Self-checking testbench for the cluster link table allocator: mirrored table, scoreboard.
module tb;
    import clta_pkg::*;

    // Clocking and run limits. The clearing pass after reset writes the whole table, and
    // a find at full count may scan the whole table, so the limit lets every word be
    // that slow several times over.
    localparam int          HALF_PERIOD = 4;
    localparam int          RESET_CYCLES = 11;
    localparam int unsigned CYCLE_LIMIT = 30_000_000;
    localparam int unsigned MAXC = DEF_MAX_CLUSTERS;
    localparam int unsigned LPS = DEF_LINKS_PER_SECTOR;

    // One command word as the sender presents it. hold makes the sender wait until
    // every outstanding reply has come back before it raises start.
    typedef struct {
        t_action             act;
        logic [CLUSTER_W-1:0] cl;
        logic [VALUE_W-1:0]   lv;
        bit                   hold;
    } t_cmd_word;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   value;
    } t_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ACTION_W-1:0]   i_action = '0;
    logic [CLUSTER_W-1:0]  i_cluster = '0;
    logic [VALUE_W-1:0]    i_link_value = '0;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [VALUE_W-1:0]    o_value;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Mirror of the block: link table, hint sector and both registers.
    logic [VALUE_W-1:0]    link_mirror [0:MAXC-1];
    int unsigned           hint_mirror;
    bit                    mounted_mirror;
    logic [CNT_W-1:0]      cnt_mirror;

    t_cmd_word             cmd_backlog [$];   // words not yet presented
    t_answer               answers_due [$];   // replies owed, oldest first
    int                    n_queued = 0;      // words pushed by the stimulus
    int                    n_sent = 0;        // words taken by the block
    int                    n_recv = 0;        // replies matched to a word
    int                    n_err = 0;
    int unsigned           gap_left = 0;
    bit                    burst = 1'b0;
    int unsigned           cycles = 0;

    cluster_link_table_allocator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_cluster    (i_cluster),
        .i_link_value (i_link_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_value      (o_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Counts above the table size saturate.
    function automatic int unsigned eff_count();
        return (cnt_mirror > MAXC) ? MAXC : int'(cnt_mirror);
    endfunction

    // Works out the reply to one word and applies its side effects to the mirror.
    function automatic t_answer allocator_answer(t_action act, logic [CLUSTER_W-1:0] cl,
                                                 logic [VALUE_W-1:0] lv);
        t_answer             a;
        int unsigned         cc, secs, first, s, n, base, steps, i, j;
        logic [VALUE_W-1:0]  cur, nxt;
        bit                  hit;
        cc = eff_count();
        a.status = ST_OK;
        a.value = '0;
        if (!mounted_mirror) begin
            a.status = ST_UNMOUNTED;
            a.value = END_MARK;
            return a;
        end
        case (act)
            ACT_FIND: begin
                // circular sector scan from the hint; the last sector may be partial
                secs = (cc + LPS - 1) / LPS;
                a.status = ST_NONE_FREE;
                a.value = END_MARK;
                hit = 1'b0;
                first = (secs != 0) ? hint_mirror % secs : 0;
                for (i = 0; i < secs && !hit; i++) begin
                    s = first + i;
                    if (s >= secs)
                        s -= secs;
                    base = s * LPS;
                    n = (s == secs - 1) ? cc - base : LPS;
                    for (j = 0; j < n && !hit; j++) begin
                        if (link_mirror[base + j] == FREE_MARK) begin
                            hit = 1'b1;
                            hint_mirror = s;
                            a.status = ST_OK;
                            a.value = base + j;
                        end
                    end
                end
            end
            ACT_SET: begin
                if (cl >= cc) begin
                    a.status = ST_RANGE;
                    a.value = END_MARK;
                end else begin
                    link_mirror[cl] = lv;
                end
            end
            ACT_GET: begin
                if (cl >= cc) begin
                    a.status = ST_RANGE;
                    a.value = END_MARK;
                end else begin
                    a.value = link_mirror[cl];
                end
            end
            default: begin
                // walk to the end marker; frees made before an error stay
                cur = cl;
                steps = 0;
                while (cur != END_MARK) begin
                    if (steps >= cc) begin
                        a.status = ST_TOO_LONG;
                        a.value = END_MARK;
                        break;
                    end
                    if (cur >= cc) begin
                        a.status = ST_RANGE;
                        a.value = END_MARK;
                        break;
                    end
                    nxt = link_mirror[cur];
                    link_mirror[cur] = FREE_MARK;
                    cur = nxt;
                    steps++;
                end
            end
        endcase
        return a;
    endfunction

    // Sender: one word per accepted handshake, random gaps with stretches of none.
    always @(posedge i_clk) begin : drive_words
        t_cmd_word w;
        bit        took;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            took = start && !busy;
            if (took) begin
                answers_due.push_back(allocator_answer(t_action'(i_action), i_cluster,
                                                       i_link_value));
                n_sent <= n_sent + 1;
                if ($urandom_range(0, 24) == 0)
                    burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 6);
            end
            if (start && !took) begin
                // word stays on the bus until busy drops
            end else if (gap_left != 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         (!cmd_backlog[0].hold || (!took && n_sent == n_recv))) begin
                w = cmd_backlog.pop_front();
                start <= 1'b1;
                i_action <= w.act;
                i_cluster <= w.cl;
                i_link_value <= w.lv;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Reply checker: every strobe must match the oldest owed reply.
    always @(posedge i_clk) begin : check_replies
        t_answer due;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                $error("reply with nothing owed: status %0d value %h", o_status, o_value);
                n_err++;
            end else begin
                due = answers_due.pop_front();
                n_recv <= n_recv + 1;
                if (o_status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_status);
                    n_err++;
                end
                if (o_value !== due.value) begin
                    $error("value: expected %h, got %h", due.value, o_value);
                    n_err++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_word(t_action a, logic [CLUSTER_W-1:0] c, logic [VALUE_W-1:0] v,
                              bit hold = 1'b0);
        t_cmd_word w;
        w.act = a;
        w.cl = c;
        w.lv = v;
        w.hold = hold || ($urandom_range(0, 39) == 0);
        cmd_backlog.push_back(w);
        n_queued++;
    endtask

    // Waits until every word queued so far has its reply, then a short settle.
    task automatic settle();
        while (n_recv != n_queued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MOUNTED)
            mounted_mirror = data[0];
        else
            cnt_mirror = data;
    endtask

    function automatic logic [CLUSTER_W-1:0] pick_index();
        int unsigned cc;
        cc = eff_count();
        return (cc == 0) ? $urandom : $urandom_range(0, cc - 1);
    endfunction

    // Cluster field biased toward the bounds and the end marker.
    function automatic logic [CLUSTER_W-1:0] rand_cluster();
        int unsigned cc;
        cc = eff_count();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return (cc == 0) ? '0 : cc - 1;
            2: return cc;
            3: return END_MARK;
            4: return $urandom;
            default: return pick_index();
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] rand_link();
        case ($urandom_range(0, 5))
            0: return FREE_MARK;
            1: return END_MARK;
            2: return $urandom;
            default: return pick_index();
        endcase
    endfunction

    // Marks a run of clusters as in use.
    task automatic fill_block(int unsigned base, int unsigned n);
        int unsigned j;
        for (j = 0; j < n; j++)
            queue_word(ACT_SET, base + j, ($urandom_range(0, 1) != 0) ? END_MARK
                                                                     : ($urandom | 1));
    endtask

    // Builds a short chain with set link, then frees it. Tails: end marker, a loop
    // back to the head, or a random word that usually breaks the walk.
    task automatic chain_seq();
        int unsigned          k, i;
        logic [CLUSTER_W-1:0] head, cur, nxt, mid;
        logic [VALUE_W-1:0]   tail;
        k = $urandom_range(1, 6);
        head = pick_index();
        cur = head;
        mid = head;
        for (i = 1; i < k; i++) begin
            nxt = pick_index();
            queue_word(ACT_SET, cur, nxt);
            cur = nxt;
            if (i == k / 2)
                mid = cur;
        end
        case ($urandom_range(0, 5))
            0: tail = $urandom;
            1: tail = head;
            default: tail = END_MARK;
        endcase
        queue_word(ACT_SET, cur, tail);
        if ($urandom_range(0, 1) != 0)
            queue_word(ACT_GET, head, $urandom);
        queue_word(ACT_CHAIN, ($urandom_range(0, 4) == 0) ? mid : head, $urandom);
        if ($urandom_range(0, 2) == 0)
            queue_word(ACT_GET, head, $urandom);
    endtask

    // Fills a run (sometimes the whole volume when it is small), looks for a free cluster,
    // and sometimes releases the run's first cluster again.
    task automatic fill_seq();
        int unsigned cc, base, n;
        cc = eff_count();
        if (cc != 0) begin
            if (cc <= 40 && $urandom_range(0, 2) == 0) begin
                base = 0;
                n = cc;
            end else begin
                base = pick_index();
                n = $urandom_range(1, 12);
                if (n > cc - base)
                    n = cc - base;
            end
            fill_block(base, n);
        end
        queue_word(ACT_FIND, $urandom, $urandom);
        if (cc != 0 && $urandom_range(0, 1) != 0)
            queue_word(ACT_CHAIN, base, $urandom);
    endtask

    task automatic random_words(int n);
        int                   target;
        logic [CLUSTER_W-1:0] c;
        target = n_queued + n;
        while (n_queued < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2: chain_seq();
                3: fill_seq();
                4, 5: begin
                    c = rand_cluster();
                    queue_word(ACT_SET, c, rand_link());
                    queue_word(ACT_GET, c, $urandom);
                end
                default: queue_word(t_action'($urandom_range(0, 3)), rand_cluster(),
                                    rand_link());
            endcase
        end
    endtask

    task automatic run_phase(bit mnt, logic [CNT_W-1:0] cnt, int n);
        settle();
        write_reg(CFG_MOUNTED, CFG_DATA_W'(mnt));
        write_reg(CFG_CLUSTER_COUNT, cnt);
        random_words(n);
    endtask

    initial begin
        int unsigned i;
        for (i = 0; i < MAXC; i++)
            link_mirror[i] = FREE_MARK;
        link_mirror[0] = END_MARK;
        hint_mirror = 0;
        mounted_mirror = 1'b0;
        cnt_mirror = CNT_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // Not mounted after reset: everything fails and nothing changes.
        queue_word(ACT_FIND, '0, '0);
        queue_word(ACT_SET, 32'd1, 32'h0000_1234);
        queue_word(ACT_GET, 32'd1, '0);

        // Full volume: bounds, chain walks, out-of-range links.
        run_phase(1'b1, CNT_RESET, 0);
        queue_word(ACT_FIND, '0, '0);
        queue_word(ACT_GET, 32'd0, '0);
        queue_word(ACT_GET, MAXC - 1, '0);
        queue_word(ACT_GET, MAXC, '0, 1'b1);
        queue_word(ACT_SET, MAXC - 1, END_MARK);
        queue_word(ACT_SET, MAXC, 32'h0000_0005);
        queue_word(ACT_CHAIN, END_MARK, '0);
        queue_word(ACT_SET, 32'd5, 32'd7);
        queue_word(ACT_SET, 32'd7, END_MARK);
        queue_word(ACT_CHAIN, 32'd5, '0);
        queue_word(ACT_GET, 32'd7, '0);
        queue_word(ACT_SET, 32'd3, 32'd20000);
        queue_word(ACT_CHAIN, 32'd3, '0);
        queue_word(ACT_GET, 32'd3, '0);

        // Empty volume: nothing in range, nothing free; a chain trips the step bound.
        run_phase(1'b1, '0, 0);
        queue_word(ACT_FIND, '0, '0);
        queue_word(ACT_GET, '0, '0);
        queue_word(ACT_CHAIN, '0, '0);
        queue_word(ACT_CHAIN, END_MARK, '0);

        // Count above the table size saturates.
        run_phase(1'b1, '1, 0);
        queue_word(ACT_GET, MAXC - 1, '0);
        queue_word(ACT_GET, MAXC, '0);

        // Entry zero pointing at itself: the walk never ends, too long.
        run_phase(1'b1, 15'd3, 0);
        queue_word(ACT_SET, '0, FREE_MARK);
        queue_word(ACT_CHAIN, 32'd1, '0);
        queue_word(ACT_SET, '0, END_MARK);

        // --- random ---
        // Two full sectors; filling sector 0 moves the hint to sector 1.
        run_phase(1'b1, 15'd256, 0);
        fill_block(0, LPS);
        queue_word(ACT_FIND, '0, '0);
        random_words(20);
        // One sector left: the hint wraps modulo the sector count.
        run_phase(1'b1, 15'd100, 0);
        queue_word(ACT_FIND, '0, '0);
        random_words(20);
        run_phase(1'b1, 15'd129, 20);
        run_phase(1'b1, 15'd1, 20);
        run_phase(1'b1, 15'd128, 30);
        run_phase(1'b1, 15'd7, 30);
        run_phase(1'b0, 15'd200, 15);
        run_phase(1'b1, 15'd40, 20);
        run_phase(1'b1, CNT_RESET, 0);
        queue_word(ACT_SET, '0, END_MARK);
        random_words(25);
        run_phase(1'b1, 15'd300, 30);

        settle();
        repeat (40) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d replies never arrived", answers_due.size());
            n_err++;
        end
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/clta_pkg.sv
rtl/core/cluster_link_table_allocator.sv
tb/tb.sv
